/* rtl/pwa_pkg.sv */
package pwa_pkg;

    localparam int COEF_W         = 48;
    localparam int XY_W           = 12;
    localparam int PIX_W          = 10;
    localparam int CFG_IDX_W      = 4;
    localparam int NUM_COEF       = 8;
    localparam int HALF_W         = COEF_W / 2;
    // Derived coefficients: a difference of two products of coefficients, or a product plus a shifted one.
    localparam int KW             = 2 * COEF_W + 2;
    // Numerators and denominator per pixel, with margin for FRAC_BITS up to 40.
    localparam int NW             = 112;
    // Quotient bits kept; any larger quotient lies outside every source image.
    localparam int QBITS          = 12;
    localparam int DW             = NW + QBITS + 2;
    localparam int PIECE_W        = 24;
    localparam int NPIECE         = KW / PIECE_W;
    localparam int PPW            = 40;
    localparam int SEQ_LEN        = 14;
    localparam int STEP_W         = 4;
    localparam int DEF_SRC_WIDTH  = 1024;
    localparam int DEF_SRC_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS  = 32;

    typedef enum logic [2:0] {
        CF_K, CF_L, CF_D, CF_E, CF_F, CF_G, CF_H, CF_I
    } t_coef_sel;

    typedef enum logic [3:0] {
        KD_DEN_Y, KD_DEN_X, KD_DEN_C,
        KD_NX_Y, KD_NX_X, KD_NX_C,
        KD_NY_Y, KD_NY_X, KD_NY_C
    } t_kd_sel;

    typedef struct packed {
        logic signed [KW-1:0] den_y;
        logic signed [KW-1:0] den_x;
        logic signed [KW-1:0] den_c;
        logic signed [KW-1:0] nx_y;
        logic signed [KW-1:0] nx_x;
        logic signed [KW-1:0] nx_c;
        logic signed [KW-1:0] ny_y;
        logic signed [KW-1:0] ny_x;
        logic signed [KW-1:0] ny_c;
    } t_kset;

    typedef struct packed {
        t_coef_sel opa;
        t_coef_sel opb;
        t_kd_sel   tgt;
        logic      sub;
        logic      first;
        logic      last;
    } t_seq_entry;

    // Product terms of the derived coefficients, grouped by target.
    function automatic t_seq_entry seq_entry(input logic [STEP_W-1:0] step);
        t_seq_entry e;
        unique case (step)
            4'd0:  e = '{opa: CF_E, opb: CF_K, tgt: KD_DEN_Y, sub: 1'b0, first: 1'b1, last: 1'b0};
            4'd1:  e = '{opa: CF_D, opb: CF_L, tgt: KD_DEN_Y, sub: 1'b1, first: 1'b0, last: 1'b1};
            4'd2:  e = '{opa: CF_G, opb: CF_L, tgt: KD_DEN_X, sub: 1'b0, first: 1'b1, last: 1'b0};
            4'd3:  e = '{opa: CF_H, opb: CF_K, tgt: KD_DEN_X, sub: 1'b1, first: 1'b0, last: 1'b1};
            4'd4:  e = '{opa: CF_D, opb: CF_H, tgt: KD_DEN_C, sub: 1'b0, first: 1'b1, last: 1'b0};
            4'd5:  e = '{opa: CF_E, opb: CF_G, tgt: KD_DEN_C, sub: 1'b1, first: 1'b0, last: 1'b1};
            4'd6:  e = '{opa: CF_F, opb: CF_L, tgt: KD_NX_Y,  sub: 1'b0, first: 1'b1, last: 1'b1};
            4'd7:  e = '{opa: CF_I, opb: CF_L, tgt: KD_NX_X,  sub: 1'b1, first: 1'b1, last: 1'b1};
            4'd8:  e = '{opa: CF_E, opb: CF_I, tgt: KD_NX_C,  sub: 1'b0, first: 1'b1, last: 1'b0};
            4'd9:  e = '{opa: CF_F, opb: CF_H, tgt: KD_NX_C,  sub: 1'b1, first: 1'b0, last: 1'b1};
            4'd10: e = '{opa: CF_F, opb: CF_K, tgt: KD_NY_Y,  sub: 1'b1, first: 1'b1, last: 1'b1};
            4'd11: e = '{opa: CF_I, opb: CF_K, tgt: KD_NY_X,  sub: 1'b0, first: 1'b1, last: 1'b1};
            4'd12: e = '{opa: CF_F, opb: CF_G, tgt: KD_NY_C,  sub: 1'b0, first: 1'b1, last: 1'b0};
            4'd13: e = '{opa: CF_D, opb: CF_I, tgt: KD_NY_C,  sub: 1'b1, first: 1'b0, last: 1'b1};
            default: e = '{opa: CF_K, opb: CF_K, tgt: KD_DEN_Y, sub: 1'b0, first: 1'b0,
                           last: 1'b0};
        endcase
        return e;
    endfunction

endpackage

/* rtl/pwa_req_if.sv */
interface pwa_req_if;
    import pwa_pkg::*;

    logic            valid;
    logic            ready;
    logic [XY_W-1:0] dest_x;
    logic [XY_W-1:0] dest_y;

    modport source (output valid, dest_x, dest_y, input ready);
    modport sink (input valid, dest_x, dest_y, output ready);
endinterface

/* rtl/pwa_rsp_if.sv */
interface pwa_rsp_if;
    import pwa_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_col;
    logic [PIX_W-1:0] src_row;
    logic             inside_res;
    logic             singular;

    modport source (output valid, src_col, src_row, inside_res, singular, input ready);
    modport sink (input valid, src_col, src_row, inside_res, singular, output ready);
endinterface

/* rtl/pwa_coef_unit.sv */
module pwa_coef_unit #(
    parameter int FRAC_BITS = pwa_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pwa_pkg::COEF_W-1:0]     i_cfg_data,
    output pwa_pkg::t_kset                 o_kset,
    output logic                           o_busy
);
    import pwa_pkg::*;

    typedef enum logic [2:0] {
        PH_LOAD, PH_P0, PH_P1, PH_P2, PH_P3, PH_APPLY
    } t_phase;

    logic signed [COEF_W-1:0] r_coef_k, r_coef_l, r_coef_d, r_coef_e;
    logic signed [COEF_W-1:0] r_coef_f, r_coef_g, r_coef_h, r_coef_i;
    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    t_phase                   r_phase;
    logic [COEF_W-1:0]        r_ma, r_mb;
    logic                     r_sgn;
    logic [2*COEF_W-1:0]      r_acc;
    logic [KW-1:0]            r_sum;
    t_kset                    r_kset;

    t_seq_entry               w_ent;
    logic signed [COEF_W-1:0] w_opa, w_opb;
    logic [COEF_W-1:0]        w_maga, w_magb;
    logic signed [KW-1:0]     w_base;
    logic [HALF_W-1:0]        w_pa, w_pb;
    logic [2*HALF_W-1:0]      w_pp;
    logic [2*COEF_W-1:0]      w_add;
    logic                     w_eff_sub;
    logic [KW-1:0]            n_sum;

    assign w_ent = seq_entry(r_step);

    function automatic logic signed [COEF_W-1:0] pick(
        input t_coef_sel s,
        input logic signed [COEF_W-1:0] k, l, d, e, f, g, h, i
    );
        logic signed [COEF_W-1:0] v;
        unique case (s)
            CF_K: v = k;
            CF_L: v = l;
            CF_D: v = d;
            CF_E: v = e;
            CF_F: v = f;
            CF_G: v = g;
            CF_H: v = h;
            CF_I: v = i;
        endcase
        return v;
    endfunction

    always_comb begin
        w_opa  = pick(w_ent.opa, r_coef_k, r_coef_l, r_coef_d, r_coef_e,
                      r_coef_f, r_coef_g, r_coef_h, r_coef_i);
        w_opb  = pick(w_ent.opb, r_coef_k, r_coef_l, r_coef_d, r_coef_e,
                      r_coef_f, r_coef_g, r_coef_h, r_coef_i);
        w_maga = w_opa[COEF_W-1] ? -w_opa : w_opa;
        w_magb = w_opb[COEF_W-1] ? -w_opb : w_opb;
    end

    // The y and x coefficients of the numerators carry a shifted gain term.
    always_comb begin
        unique case (w_ent.tgt)
            KD_NX_Y: w_base = -(KW'(r_coef_e) <<< FRAC_BITS);
            KD_NX_X: w_base = KW'(r_coef_h) <<< FRAC_BITS;
            KD_NY_Y: w_base = KW'(r_coef_d) <<< FRAC_BITS;
            KD_NY_X: w_base = -(KW'(r_coef_g) <<< FRAC_BITS);
            default: w_base = '0;
        endcase
    end

    // One half-by-half partial product of the magnitudes per cycle.
    always_comb begin
        unique case (r_phase)
            PH_P1:   begin w_pa = r_ma[HALF_W-1:0];      w_pb = r_mb[COEF_W-1:HALF_W]; end
            PH_P2:   begin w_pa = r_ma[COEF_W-1:HALF_W]; w_pb = r_mb[HALF_W-1:0];      end
            PH_P3:   begin w_pa = r_ma[COEF_W-1:HALF_W]; w_pb = r_mb[COEF_W-1:HALF_W]; end
            default: begin w_pa = r_ma[HALF_W-1:0];      w_pb = r_mb[HALF_W-1:0];      end
        endcase
        w_pp = (2*HALF_W)'(w_pa) * (2*HALF_W)'(w_pb);
        unique case (r_phase)
            PH_P1, PH_P2: w_add = (2*COEF_W)'(w_pp) << HALF_W;
            PH_P3:        w_add = (2*COEF_W)'(w_pp) << (2*HALF_W);
            default:      w_add = (2*COEF_W)'(w_pp);
        endcase
    end

    assign w_eff_sub = w_ent.sub ^ r_sgn;
    assign n_sum     = w_eff_sub ? r_sum - KW'(r_acc) : r_sum + KW'(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_k <= '0;
            r_coef_l <= '0;
            r_coef_d <= COEF_W'(1) << FRAC_BITS;
            r_coef_e <= '0;
            r_coef_f <= '0;
            r_coef_g <= '0;
            r_coef_h <= COEF_W'(1) << FRAC_BITS;
            r_coef_i <= '0;
            r_busy   <= 1'b1;
            r_step   <= '0;
            r_phase  <= PH_LOAD;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_IDX_W'(NUM_COEF)) begin
                unique case (t_coef_sel'(i_cfg_idx[$bits(t_coef_sel)-1:0]))
                    CF_K: r_coef_k <= i_cfg_data;
                    CF_L: r_coef_l <= i_cfg_data;
                    CF_D: r_coef_d <= i_cfg_data;
                    CF_E: r_coef_e <= i_cfg_data;
                    CF_F: r_coef_f <= i_cfg_data;
                    CF_G: r_coef_g <= i_cfg_data;
                    CF_H: r_coef_h <= i_cfg_data;
                    CF_I: r_coef_i <= i_cfg_data;
                endcase
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_phase <= PH_LOAD;
            end
        end else if (r_busy) begin
            unique case (r_phase)
                PH_LOAD: begin
                    r_ma  <= w_maga;
                    r_mb  <= w_magb;
                    r_sgn <= w_opa[COEF_W-1] ^ w_opb[COEF_W-1];
                    if (w_ent.first) begin
                        r_sum <= w_base;
                    end
                    r_phase <= PH_P0;
                end
                PH_P0: begin
                    r_acc   <= w_add;
                    r_phase <= PH_P1;
                end
                PH_P1: begin
                    r_acc   <= r_acc + w_add;
                    r_phase <= PH_P2;
                end
                PH_P2: begin
                    r_acc   <= r_acc + w_add;
                    r_phase <= PH_P3;
                end
                PH_P3: begin
                    r_acc   <= r_acc + w_add;
                    r_phase <= PH_APPLY;
                end
                PH_APPLY: begin
                    r_sum <= n_sum;
                    if (w_ent.last) begin
                        unique case (w_ent.tgt)
                            KD_DEN_Y: r_kset.den_y <= n_sum;
                            KD_DEN_X: r_kset.den_x <= n_sum;
                            KD_DEN_C: r_kset.den_c <= n_sum;
                            KD_NX_Y:  r_kset.nx_y  <= n_sum;
                            KD_NX_X:  r_kset.nx_x  <= n_sum;
                            KD_NX_C:  r_kset.nx_c  <= n_sum;
                            KD_NY_Y:  r_kset.ny_y  <= n_sum;
                            KD_NY_X:  r_kset.ny_x  <= n_sum;
                            KD_NY_C:  r_kset.ny_c  <= n_sum;
                            default:  r_kset.den_c <= r_kset.den_c;
                        endcase
                    end
                    if (r_step == STEP_W'(SEQ_LEN - 1)) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                    r_phase <= PH_LOAD;
                end
                default: r_phase <= PH_LOAD;
            endcase
        end
    end

    assign o_kset = r_kset;
    assign o_busy = r_busy;

endmodule

/* rtl/pwa_div_step.sv */
module pwa_div_step #(
    parameter int SHIFT = 0
) (
    input  logic [pwa_pkg::DW-1:0] i_rem,
    input  logic [pwa_pkg::DW-1:0] i_div,
    output logic [pwa_pkg::DW-1:0] o_rem,
    output logic                   o_take
);
    import pwa_pkg::*;

    logic [DW:0] w_diff;

    assign w_diff = {1'b0, i_rem} - {1'b0, i_div << SHIFT};
    assign o_take = !w_diff[DW];
    assign o_rem  = o_take ? w_diff[DW-1:0] : i_rem;

endmodule

/* rtl/perspective_inverse_warp_address.sv */
// Inverse perspective warp address generator. Each request carries a destination
// pixel (dest_x, dest_y); the response gives the source pixel under the inverse of
// the eight-coefficient perspective mapping, each quotient rounded half away from
// zero, with inside_res set when it falls within SRC_WIDTH x SRC_HEIGHT and
// singular set when the denominator is exactly zero. The pipeline takes one request
// per clock unless o_rsp.ready holds it back or coefficients are being updated;
// three stages form the numerators and denominator from precomputed coefficients,
// three more take magnitudes and the range check, and twelve restoring steps
// produce the rounded quotient, one bit each, before the output register. After
// reset and after every write to a known coefficient register, a shared 24x24
// multiplier forms the fourteen coefficient products, and no request is accepted
// meanwhile. Coefficients are signed with FRAC_BITS fraction bits and are written
// at indexes 0 to 7 in the order k, l, d, e, f, g, h, i.
module perspective_inverse_warp_address #(
    parameter int SRC_WIDTH  = pwa_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = pwa_pkg::DEF_SRC_HEIGHT,
    parameter int FRAC_BITS  = pwa_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pwa_req_if.sink                        i_req,
    pwa_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pwa_pkg::COEF_W-1:0]     i_cfg_data
);
    import pwa_pkg::*;

    localparam int NTERM  = 6;
    localparam int V_MUL  = 0;
    localparam int V_TERM = 1;
    localparam int V_SUM  = 2;
    localparam int V_ABS  = 3;
    localparam int V_AB   = 4;
    localparam int V_DIV0 = 5;
    localparam int V_OUT  = V_DIV0 + QBITS + 1;
    localparam int NS     = V_OUT + 1;

    t_kset                w_kset;
    logic                 w_busy;
    logic signed [KW-1:0] w_kmul [NTERM];
    logic [NS-1:0]        w_en;
    logic                 w_in_fire;

    logic [NS-1:0]         r_v;
    logic signed [PPW-1:0] r_pp [NTERM][NPIECE];
    logic signed [PPW-1:0] w_pp [NTERM][NPIECE];
    logic signed [NW-1:0]  r_term [NTERM];
    logic signed [NW-1:0]  w_term [NTERM];
    logic signed [NW-1:0]  r_den, r_nx, r_ny;
    logic [NW-1:0]         r_aden, r_anx, r_any;
    logic                  r_negx3, r_negy3, r_sing3;
    logic [DW-1:0]         r_ax, r_ay, r_bq;
    logic                  r_negx4, r_negy4, r_sing4;

    logic [DW-1:0]    r_rx [QBITS+1];
    logic [DW-1:0]    r_ry [QBITS+1];
    logic [DW-1:0]    r_b  [QBITS+1];
    logic [QBITS-1:0] r_qx [QBITS+1];
    logic [QBITS-1:0] r_qy [QBITS+1];
    logic             r_ovfx [QBITS+1];
    logic             r_ovfy [QBITS+1];
    logic             r_negx [QBITS+1];
    logic             r_negy [QBITS+1];
    logic             r_sg   [QBITS+1];

    logic             w_okx, w_oky, w_inside;
    logic [PIX_W-1:0] r_col, r_row;
    logic             r_inside, r_sing;

    pwa_coef_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_kset     (w_kset),
        .o_busy     (w_busy)
    );

    assign w_kmul[0] = w_kset.den_y;
    assign w_kmul[1] = w_kset.den_x;
    assign w_kmul[2] = w_kset.nx_y;
    assign w_kmul[3] = w_kset.nx_x;
    assign w_kmul[4] = w_kset.ny_y;
    assign w_kmul[5] = w_kset.ny_x;

    // A stage may load when it is empty or when the stage after it moves on.
    assign w_en[NS-1] = !r_v[NS-1] || o_rsp.ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    assign i_req.ready = w_en[0] && !w_busy;
    assign w_in_fire   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_in_fire;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Derived coefficients times the coordinate, cut into narrow pieces.
    always_comb begin
        logic [XY_W-1:0] mcand;
        for (int t = 0; t < NTERM; t++) begin
            mcand = ((t & 1) == 0) ? i_req.dest_y : i_req.dest_x;
            for (int p = 0; p < NPIECE - 1; p++) begin
                w_pp[t][p] = PPW'($signed({1'b0, w_kmul[t][p*PIECE_W +: PIECE_W]})
                                  * $signed({1'b0, mcand}));
            end
            w_pp[t][NPIECE-1] = PPW'($signed(w_kmul[t][KW-1:(NPIECE-1)*PIECE_W])
                                     * $signed({1'b0, mcand}));
        end
    end

    always_comb begin
        for (int t = 0; t < NTERM; t++) begin
            w_term[t] = '0;
            for (int p = 0; p < NPIECE; p++) begin
                w_term[t] = w_term[t] + (NW'(r_pp[t][p]) <<< (p * PIECE_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[V_MUL]) begin
            r_pp <= w_pp;
        end
        if (w_en[V_TERM]) begin
            r_term <= w_term;
        end
        if (w_en[V_SUM]) begin
            r_den <= r_term[0] + r_term[1] + NW'(w_kset.den_c);
            r_nx  <= r_term[2] + r_term[3] + NW'(w_kset.nx_c);
            r_ny  <= r_term[4] + r_term[5] + NW'(w_kset.ny_c);
        end
        if (w_en[V_ABS]) begin
            r_aden  <= r_den[NW-1] ? -r_den : r_den;
            r_anx   <= r_nx[NW-1] ? -r_nx : r_nx;
            r_any   <= r_ny[NW-1] ? -r_ny : r_ny;
            r_negx3 <= r_nx[NW-1] ^ r_den[NW-1];
            r_negy3 <= r_ny[NW-1] ^ r_den[NW-1];
            r_sing3 <= (r_den == '0);
        end
        // Rounding half away from zero: floor((2|n| + |d|) / (2|d|)).
        if (w_en[V_AB]) begin
            r_ax    <= DW'({r_anx, 1'b0}) + DW'(r_aden);
            r_ay    <= DW'({r_any, 1'b0}) + DW'(r_aden);
            r_bq    <= DW'({r_aden, 1'b0});
            r_negx4 <= r_negx3;
            r_negy4 <= r_negy3;
            r_sing4 <= r_sing3;
        end
        if (w_en[V_DIV0]) begin
            r_rx[0]   <= r_ax;
            r_ry[0]   <= r_ay;
            r_b[0]    <= r_bq;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_ovfx[0] <= r_ax >= (r_bq << QBITS);
            r_ovfy[0] <= r_ay >= (r_bq << QBITS);
            r_negx[0] <= r_negx4;
            r_negy[0] <= r_negy4;
            r_sg[0]   <= r_sing4;
        end
    end

    for (genvar s = 1; s <= QBITS; s++) begin : g_div
        logic [DW-1:0] w_remx, w_remy;
        logic          w_takex, w_takey;

        pwa_div_step #(.SHIFT(QBITS - s)) u_stepx (
            .i_rem  (r_rx[s-1]),
            .i_div  (r_b[s-1]),
            .o_rem  (w_remx),
            .o_take (w_takex)
        );

        pwa_div_step #(.SHIFT(QBITS - s)) u_stepy (
            .i_rem  (r_ry[s-1]),
            .i_div  (r_b[s-1]),
            .o_rem  (w_remy),
            .o_take (w_takey)
        );

        always_ff @(posedge i_clk) begin
            if (w_en[V_DIV0 + s]) begin
                r_rx[s]   <= w_remx;
                r_ry[s]   <= w_remy;
                r_b[s]    <= r_b[s-1];
                r_qx[s]   <= r_qx[s-1] | (QBITS'(w_takex) << (QBITS - s));
                r_qy[s]   <= r_qy[s-1] | (QBITS'(w_takey) << (QBITS - s));
                r_ovfx[s] <= r_ovfx[s-1];
                r_ovfy[s] <= r_ovfy[s-1];
                r_negx[s] <= r_negx[s-1];
                r_negy[s] <= r_negy[s-1];
                r_sg[s]   <= r_sg[s-1];
            end
        end
    end

    // A quotient that rounds to zero is inside whatever its sign.
    assign w_okx = !r_ovfx[QBITS] && ((r_qx[QBITS] == '0) || (!r_negx[QBITS]
                   && ({1'b0, r_qx[QBITS]} < (QBITS+1)'(SRC_WIDTH))));
    assign w_oky = !r_ovfy[QBITS] && ((r_qy[QBITS] == '0) || (!r_negy[QBITS]
                   && ({1'b0, r_qy[QBITS]} < (QBITS+1)'(SRC_HEIGHT))));
    assign w_inside = w_okx && w_oky && !r_sg[QBITS];

    always_ff @(posedge i_clk) begin
        if (w_en[V_OUT]) begin
            r_col    <= w_inside ? r_qx[QBITS][PIX_W-1:0] : '0;
            r_row    <= w_inside ? r_qy[QBITS][PIX_W-1:0] : '0;
            r_inside <= w_inside;
            r_sing   <= r_sg[QBITS];
        end
    end

    assign o_rsp.valid      = r_v[V_OUT];
    assign o_rsp.src_col    = r_col;
    assign o_rsp.src_row    = r_row;
    assign o_rsp.inside_res = r_inside;
    assign o_rsp.singular   = r_sing;

endmodule
